// ===== rtl/hppp_pkg.sv =====
// Shared types, character codes and status codes of the IPv6 host/port/prefix parser.
package hppp_pkg;

  localparam int CH_W     = 8;
  localparam int STATUS_W = 2;
  localparam int FIELD_W  = 9;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SYNTAX = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LONG   = 2'd2;

  // Characters with a meaning to the parser
  localparam logic [CH_W-1:0] CH_NUL      = 8'h00;
  localparam logic [CH_W-1:0] CH_LBRACKET = 8'h5B;  // '['
  localparam logic [CH_W-1:0] CH_RBRACKET = 8'h5D;  // ']'
  localparam logic [CH_W-1:0] CH_PERCENT  = 8'h25;  // '%'
  localparam logic [CH_W-1:0] CH_COLON    = 8'h3A;  // ':'
  localparam logic [CH_W-1:0] CH_SLASH    = 8'h2F;  // '/'

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  host_length;
    logic [FIELD_W-1:0]  port_offset;
    logic [FIELD_W-1:0]  port_length;
    logic [FIELD_W-1:0]  prefix_offset;
    logic [FIELD_W-1:0]  prefix_length;
  } result_t;

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // Hex digits of either case, plus the group separator
  function automatic logic is_host_char(input logic [CH_W-1:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46)) || (c == CH_COLON);
  endfunction

endpackage

// ===== rtl/hppp_ifs.sv =====
// Valid/ready channel interfaces: character input and parse result output.
interface hppp_char_if import hppp_pkg::*;;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface hppp_result_if import hppp_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FIELD_W-1:0]  host_length;
  logic [FIELD_W-1:0]  port_offset;
  logic [FIELD_W-1:0]  port_length;
  logic [FIELD_W-1:0]  prefix_offset;
  logic [FIELD_W-1:0]  prefix_length;

  modport source (output valid, output status, output host_length, output port_offset,
                  output port_length, output prefix_offset, output prefix_length,
                  input ready);
  modport sink   (input valid, input status, input host_length, input port_offset,
                  input port_length, input prefix_offset, input prefix_length,
                  output ready);
endinterface

// ===== rtl/hppp_core.sv =====
// Parse state machine: mode, position, sticky status and field offsets, one character a step.
module hppp_core import hppp_pkg::*; #(
  parameter int MAX_LEN = 255
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [CH_W-1:0] ch,
  output result_t         res
);

  localparam int PW = $clog2(MAX_LEN + 1);
  localparam int FW = $clog2(MAX_LEN + 2);

  typedef enum logic [2:0] {
    MODE_BRACKET,
    MODE_HOST,
    MODE_IFACE,
    MODE_AFTER,
    MODE_PORT,
    MODE_PREFIX
  } mode_t;

  mode_t               mode, mode_next;
  logic [PW-1:0]       pos, pos_next;
  logic [STATUS_W-1:0] err, err_next;
  logic [FW-1:0]       host_len, host_len_next;
  logic [FW-1:0]       port_off, port_off_next;
  logic [FW-1:0]       port_len, port_len_next;
  logic [FW-1:0]       prefix_off, prefix_off_next;
  logic [FW-1:0]       prefix_len;
  logic [FW-1:0]       pos_w;
  logic                nul;
  logic                live;

  assign nul   = (ch == CH_NUL);
  assign pos_w = FW'(pos);

  // Next-state logic for one character
  always_comb begin
    mode_next       = mode;
    pos_next        = pos;
    err_next        = err;
    host_len_next   = host_len;
    port_off_next   = port_off;
    port_len_next   = port_len;
    prefix_off_next = prefix_off;
    prefix_len      = '0;

    // Length limit is checked before the character is parsed
    if ((err == ST_OK) && !nul && (pos >= PW'(MAX_LEN))) begin
      err_next = ST_LONG;
    end
    live = (err_next == ST_OK);

    if (live) begin
      unique case (mode)
        MODE_BRACKET: begin
          if (ch == CH_LBRACKET) mode_next = MODE_HOST;
          else                   err_next  = ST_SYNTAX;
        end
        MODE_HOST: begin
          if ((ch == CH_RBRACKET) || nul || (ch == CH_PERCENT)) begin
            host_len_next = pos_w - FW'(1);
            if (pos_w == FW'(1)) err_next = ST_SYNTAX;
            mode_next = (ch == CH_PERCENT) ? MODE_IFACE : MODE_AFTER;
          end else if (!is_host_char(ch)) begin
            err_next = ST_SYNTAX;
          end
        end
        MODE_IFACE: begin
          if (ch == CH_RBRACKET) mode_next = MODE_AFTER;
          else if (nul)          err_next  = ST_SYNTAX;
        end
        MODE_AFTER: begin
          // anything other than ':' or '/' is skipped here
          if (ch == CH_COLON) begin
            mode_next     = MODE_PORT;
            port_off_next = pos_w + FW'(1);
          end else if (ch == CH_SLASH) begin
            mode_next       = MODE_PREFIX;
            prefix_off_next = pos_w + FW'(1);
          end
        end
        MODE_PORT: begin
          if ((ch == CH_SLASH) || nul) begin
            port_len_next   = pos_w - port_off;
            prefix_off_next = pos_w + FW'(1);
            mode_next       = MODE_PREFIX;
            if (pos_w == port_off) err_next = ST_SYNTAX;
          end else if (!is_digit(ch)) begin
            err_next = ST_SYNTAX;
          end
        end
        MODE_PREFIX: begin
          if (nul) begin
            prefix_len = pos_w - prefix_off;
            if (pos_w == prefix_off) err_next = ST_SYNTAX;
          end else if (!is_digit(ch)) begin
            err_next = ST_SYNTAX;
          end
        end
        default: begin
          err_next = ST_SYNTAX;
        end
      endcase
      if (!nul && (pos < PW'(MAX_LEN))) pos_next = pos + PW'(1);
    end
  end

  // Result as seen at a terminating NUL; fields are zero on any error
  always_comb begin
    res        = '0;
    res.status = err_next;
    if (err_next == ST_OK) begin
      res.host_length   = FIELD_W'(host_len_next);
      res.port_offset   = FIELD_W'(port_off_next);
      res.port_length   = FIELD_W'(port_len_next);
      res.prefix_offset = FIELD_W'(prefix_off_next);
      res.prefix_length = FIELD_W'(prefix_len);
    end
  end

  // State registers; a NUL restarts the parse
  always_ff @(posedge clk) begin
    if (rst || (step && nul)) begin
      mode       <= MODE_BRACKET;
      pos        <= '0;
      err        <= ST_OK;
      host_len   <= '0;
      port_off   <= '0;
      port_len   <= '0;
      prefix_off <= '0;
    end else if (step) begin
      mode       <= mode_next;
      pos        <= pos_next;
      err        <= err_next;
      host_len   <= host_len_next;
      port_off   <= port_off_next;
      port_len   <= port_len_next;
      prefix_off <= prefix_off_next;
    end
  end

endmodule

// ===== rtl/ipv6_host_port_prefix_parser.sv =====
// Top level of the bracketed IPv6 host/port/prefix parser.
//
//  channel  direction  payload                                        item
//  text     in         ch[7:0]                                        one character
//  result   out        status, host_length, port_offset, port_length, one parse result
//                      prefix_offset, prefix_length
//
// One character per cycle sustained, except while a NUL waits on a full result register.
// A NUL passes the input register and the parse logic; its result is held in the result
// register. Only a NUL waits on a full result register; other characters pass.
// Reset (rst, synchronous) empties both registers and returns the parser to its start.
// The next text may start the cycle after a NUL.
module ipv6_host_port_prefix_parser import hppp_pkg::*; #(
  parameter int MAX_LEN = 255
) (
  input  logic            clk,
  input  logic            rst,
  hppp_char_if.sink       text,
  hppp_result_if.source   result
);

  logic            s1_valid;
  logic [CH_W-1:0] s1_ch;
  logic            s1_nul;
  logic            advance;
  logic            out_valid;
  result_t         out_res;
  result_t         core_res;

  // A held NUL may move on only when the result register is free or draining
  assign s1_nul     = (s1_ch == CH_NUL);
  assign advance    = s1_valid && (!s1_nul || !out_valid || result.ready);
  assign text.ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.ready) begin
      s1_valid <= text.valid;
    end
    if (text.valid && text.ready) begin
      s1_ch <= text.ch;
    end
  end

  hppp_core #(.MAX_LEN(MAX_LEN)) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .ch   (s1_ch),
    .res  (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_nul) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (advance && s1_nul) begin
      out_res <= core_res;
    end
  end

  assign result.valid         = out_valid;
  assign result.status        = out_res.status;
  assign result.host_length   = out_res.host_length;
  assign result.port_offset   = out_res.port_offset;
  assign result.port_length   = out_res.port_length;
  assign result.prefix_offset = out_res.prefix_offset;
  assign result.prefix_length = out_res.prefix_length;

endmodule

// ===== rtl/hppp_checker.sv =====
// Port-level assertions for the IPv6 host/port/prefix parser, bound to the top level.
module hppp_checker import hppp_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                text_valid,
  input logic                text_ready,
  input logic                result_valid,
  input logic                result_ready,
  input logic [STATUS_W-1:0] status,
  input logic [FIELD_W-1:0]  host_length,
  input logic [FIELD_W-1:0]  port_offset,
  input logic [FIELD_W-1:0]  port_length,
  input logic [FIELD_W-1:0]  prefix_offset,
  input logic [FIELD_W-1:0]  prefix_length
);

  // Input backs up only behind a stalled result
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    (text_valid && !text_ready) |-> (result_valid && !result_ready))
    else $error("text stalled while result side is free");

  // Only the three defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status == ST_OK || status == ST_SYNTAX || status == ST_LONG))
    else $error("undefined status code");

  // A failed parse reports no field values
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != ST_OK) |->
      (host_length == '0 && port_offset == '0 && port_length == '0 &&
       prefix_offset == '0 && prefix_length == '0))
    else $error("error result carries field values");

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(status) && $stable(host_length) &&
       $stable(port_offset) && $stable(port_length) &&
       $stable(prefix_offset) && $stable(prefix_length)))
    else $error("stalled result changed");

endmodule

bind ipv6_host_port_prefix_parser hppp_checker u_hppp_checker (
  .clk           (clk),
  .rst           (rst),
  .text_valid    (text.valid),
  .text_ready    (text.ready),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .status        (result.status),
  .host_length   (result.host_length),
  .port_offset   (result.port_offset),
  .port_length   (result.port_length),
  .prefix_offset (result.prefix_offset),
  .prefix_length (result.prefix_length)
);
